/* rtl/core/exp_weighted_window_smoother_macros.svh */
// Assertion macros for the exponentially weighted window smoother.
// Included by the port checker; no other dependencies.
`ifndef EXP_WEIGHTED_WINDOW_SMOOTHER_MACROS_SVH
`define EXP_WEIGHTED_WINDOW_SMOOTHER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EWWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ewws check failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define EWWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ewws check failed: next-cycle implication");

`endif

/* rtl/core/ewws_pkg.sv */
// Shared types and constants of the exponentially weighted window smoother.
// No dependencies.
package ewws_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int SMOOTH_W  = 16;
  localparam int FRAC_BITS = 6;
  localparam int WEIGHT_W  = 17;
  localparam int Q_BITS    = 16;
  localparam int CHANNELS  = 4;
  localparam int DIV_STEPS = 16;

  localparam logic [WEIGHT_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [WEIGHT_W-1:0] RATIO_RESET = 17'd58982;

  // Per-item commands from the sequencer to every lane
  typedef struct packed {
    logic wr_en;     // store the new sample
    logic clr;       // clear accumulators
    logic acc;       // accumulate the tap on the read port
    logic div_load;  // seed the divider
    logic div_step;  // one quotient bit
  } lane_ctrl_t;

endpackage

/* rtl/core/ewws_lane.sv */
// One channel lane: sample history memory, weighted accumulator and bit-serial divider.
// Depends on ewws_pkg.
module ewws_lane #(
  parameter int HISTORY_DEPTH = 8,
  parameter int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                          clk,
  input  ewws_pkg::lane_ctrl_t          ctl,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [ewws_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [ewws_pkg::WEIGHT_W-1:0] weight,
  output logic [ewws_pkg::SMOOTH_W-1:0] quo
);
  import ewws_pkg::*;

  localparam int LOG_D  = $clog2(HISTORY_DEPTH);
  localparam int PROD_W = SAMPLE_W + WEIGHT_W - 1;  // w <= 2^16, x <= 1023
  localparam int NUM_W  = PROD_W + LOG_D;
  localparam int DEN_W  = WEIGHT_W + LOG_D;

  logic [SAMPLE_W-1:0]          mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0]          rd_data;
  logic [SAMPLE_W+WEIGHT_W-1:0] prod;
  logic [NUM_W-1:0]             num;
  logic [DEN_W-1:0]             den;
  logic [DEN_W-1:0]             rem;
  logic [SMOOTH_W-1:0]          lo;
  logic [DEN_W:0]               trial;
  logic                         ge;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign prod = weight * rd_data;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      num <= '0;
      den <= '0;
    end else if (ctl.acc) begin
      num <= num + NUM_W'(prod);
      den <= den + DEN_W'(weight);
    end
  end

  // Dividend is num * 64; its upper part (num >> 10) is below den since
  // the weighted mean never exceeds the largest sample.
  assign trial = {rem, lo[SMOOTH_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem <= DEN_W'(num >> (SMOOTH_W - FRAC_BITS));
      lo  <= SMOOTH_W'(num << FRAC_BITS);
      quo <= '0;
    end else if (ctl.div_step) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
      lo  <= lo << 1;
      quo <= {quo[SMOOTH_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/ewws_ctrl.sv */
// Sequencer: ring pointer, fill count, tap walk, shared weight generator, divide count.
// Depends on ewws_pkg.
module ewws_ctrl #(
  parameter int HISTORY_DEPTH = 8,
  parameter int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
  parameter int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ewws_pkg::WEIGHT_W-1:0] ratio,
  output ewws_pkg::lane_ctrl_t          ctl,
  output logic [AW-1:0]                 wr_addr,
  output logic [AW-1:0]                 rd_addr,
  output logic [ewws_pkg::WEIGHT_W-1:0] weight,
  output logic                          out_load
);
  import ewws_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(HISTORY_DEPTH);
  localparam int            DCW       = $clog2(DIV_STEPS);

  logic [1:0]              state;
  logic [AW-1:0]           slot;
  logic [AW-1:0]           slot_next;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           cnt;
  logic                    tap_v;
  logic [DCW-1:0]          div_cnt;
  logic                    accept;
  logic                    walk_done;
  logic [WEIGHT_W-1:0]     ratio_c;
  logic [2*WEIGHT_W-1:0]   wprod;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign walk_done = (state == S_WALK) && (cnt == fill) && !tap_v;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    if (fill == '0) begin
      slot_next = '0;
    end else if (slot == LAST_SLOT) begin
      slot_next = '0;
    end else begin
      slot_next = slot + AW'(1);
    end
  end

  assign wr_addr = slot_next;

  always_comb begin
    ctl.wr_en    = accept;
    ctl.clr      = accept;
    ctl.acc      = tap_v;
    ctl.div_load = walk_done;
    ctl.div_step = (state == S_DIV);
  end

  // Ratios above one act as one
  assign ratio_c = (ratio > ONE_Q16) ? ONE_Q16 : ratio;
  assign wprod   = weight * ratio_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      fill      <= '0;
      tap_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            slot  <= slot_next;
            if (fill != FULL) begin
              fill <= fill + CW'(1);
            end
            state <= S_WALK;
          end
        end
        S_WALK: begin
          tap_v <= (cnt != fill);
          if (walk_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == DCW'(DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Walk taps newest to oldest; read data is registered and arrives in the cycle after its address
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addr <= slot_next;
      cnt     <= '0;
      weight  <= ONE_Q16;
      div_cnt <= '0;
    end else begin
      if (state == S_WALK && cnt != fill) begin
        rd_addr <= (rd_addr == '0) ? LAST_SLOT : rd_addr - AW'(1);
        cnt     <= cnt + CW'(1);
      end
      if (tap_v) begin
        weight <= WEIGHT_W'(wprod >> Q_BITS);
      end
      if (state == S_DIV) begin
        div_cnt <= div_cnt + DCW'(1);
      end
    end
  end

endmodule

/* rtl/core/exp_weighted_window_smoother.sv */
// Top level of the exponentially weighted window smoother: config register,
// sequencer, four channel lanes and the result register. Depends on ewws_pkg, ewws_ctrl and ewws_lane.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | lf/ll/rr/rf_sample, 10 bits each
//   out     | out_valid/ out_ready | lf/ll/rr/rf_smooth, 16 bits each, Q10.6
//   cfg     | cfg_we (no wait)     | cfg_data -> decay_ratio, 17 bits
//
// One request runs from accept to result as a one-tap-per-cycle walk of the
// history memories, then a restoring divide in each lane.
// A result may sit in the output register while the next request is taken;
// the lanes stall before the result load until it is taken.
// Reset (rst, synchronous) empties the history and restores decay_ratio.
module exp_weighted_window_smoother #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ewws_pkg::SAMPLE_W-1:0]       lf_sample,
  input  logic [ewws_pkg::SAMPLE_W-1:0]       ll_sample,
  input  logic [ewws_pkg::SAMPLE_W-1:0]       rr_sample,
  input  logic [ewws_pkg::SAMPLE_W-1:0]       rf_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ewws_pkg::SMOOTH_W-1:0]       lf_smooth,
  output logic [ewws_pkg::SMOOTH_W-1:0]       ll_smooth,
  output logic [ewws_pkg::SMOOTH_W-1:0]       rr_smooth,
  output logic [ewws_pkg::SMOOTH_W-1:0]       rf_smooth,
  input  logic                                cfg_we,
  input  logic [ewws_pkg::WEIGHT_W-1:0]       cfg_data
);
  import ewws_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [WEIGHT_W-1:0] decay_ratio;
  lane_ctrl_t          ctl;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [WEIGHT_W-1:0] weight;
  logic                out_load;
  logic [SAMPLE_W-1:0] samples [CHANNELS];
  logic [SMOOTH_W-1:0] quo     [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      decay_ratio <= cfg_data;
    end
  end

  ewws_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ratio     (decay_ratio),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .weight    (weight),
    .out_load  (out_load)
  );

  assign samples[0] = lf_sample;
  assign samples[1] = ll_sample;
  assign samples[2] = rr_sample;
  assign samples[3] = rf_sample;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    ewws_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .wr_data (samples[ch]),
      .weight  (weight),
      .quo     (quo[ch])
    );
  end

  // Merge lane quotients into the result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      lf_smooth <= quo[0];
      ll_smooth <= quo[1];
      rr_smooth <= quo[2];
      rf_smooth <= quo[3];
    end
  end

endmodule

/* rtl/core/ewws_checker.sv */
// Port-level checks for the exponentially weighted window smoother, bound to the top.
// Depends on exp_weighted_window_smoother_macros.svh.
`include "exp_weighted_window_smoother_macros.svh"

module ewws_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] lf_smooth,
  input logic [15:0] ll_smooth,
  input logic [15:0] rr_smooth,
  input logic [15:0] rf_smooth
);

  // A stalled result holds (checked on the lf and rf channels)
  `EWWS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(lf_smooth) && $stable(rf_smooth))

  // One request at a time: no accept on the cycle after an accept
  `EWWS_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // A weighted mean of 10-bit samples never exceeds 64 * 1023
  `EWWS_ASSERT_IMPL(a_range, clk, rst, out_valid, lf_smooth <= 16'd65472 && ll_smooth <= 16'd65472 && rr_smooth <= 16'd65472 && rf_smooth <= 16'd65472)

endmodule

bind exp_weighted_window_smoother ewws_checker u_ewws_checker (.*);
